@@ rtl/mag_pkg.sv @@
package mag_pkg;

	localparam int VALUE_BITS = 31;
	localparam int MAX_COUNT_DEF = 1024;

	// input word
	typedef struct packed {
		logic [VALUE_BITS-1:0] sample_value;
		logic                  end_of_set;
	} item_t;

	// result word
	typedef struct packed {
		logic [VALUE_BITS-1:0] max_gap;
		logic                  overflowed;
	} result_t;

	// queue entry between front and back
	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  store;
		logic                  last;
		logic                  ovf;
	} qent_t;

	// bucket memory entry
	typedef struct packed {
		logic                  used;
		logic [VALUE_BITS-1:0] low;
		logic [VALUE_BITS-1:0] high;
	} bkt_t;

	// queue status seen by the front
	typedef struct packed {
		logic       full;
		logic [1:0] level;
	} qstat_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_PREP,
		ST_DIV_W,
		ST_DIV_N,
		ST_LOAD,
		ST_DIV_S,
		ST_BREAD,
		ST_SCAN,
		ST_TAIL,
		ST_OUT
	} bstate_t;

endpackage

@@ rtl/mag_div.sv @@
module mag_div #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         done,
	output logic [W-1:0] quo
);

	localparam int CNTW = $clog2(W + 1);

	logic            run_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [W:0]      rem_q;
	logic [W-1:0]    q_q;
	logic [W-1:0]    den_q;
	logic [W:0]      shl;
	logic [W:0]      trial;

	// one quotient bit per cycle, restoring
	always_comb begin
		shl   = {rem_q[W-1:0], q_q[W-1]};
		trial = shl - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNTW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			q_q   <= num;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= trial[W] ? shl : trial;
			q_q   <= {q_q[W-2:0], ~trial[W]};
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

@@ rtl/mag_front.sv @@
module mag_front #(
	parameter int MAX_COUNT = mag_pkg::MAX_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  mag_pkg::item_t  item,
	input  mag_pkg::qstat_t qstat,
	output logic            busy,
	output logic            push,
	output mag_pkg::qent_t  pdata
);

	localparam int CW = $clog2(MAX_COUNT + 1);

	logic [CW-1:0] cnt_q;
	logic          ovf_q;
	logic          acc;
	logic          room;

	assign busy = qstat.full;
	assign acc  = start && !qstat.full;
	assign room = cnt_q < CW'(MAX_COUNT);

	// classify: store or drop, carry the overflow mark
	always_comb begin
		pdata.value = item.sample_value;
		pdata.store = room;
		pdata.last  = item.end_of_set;
		pdata.ovf   = ovf_q || !room;
	end
	assign push = acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (acc) begin
			if (item.end_of_set) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (room) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/mag_fifo.sv @@
module mag_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mag_pkg::qent_t  wdata,
	input  logic            pop,
	output logic            valid,
	output mag_pkg::qent_t  rdata,
	output mag_pkg::qstat_t qstat
);

	mag_pkg::qent_t mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] lvl_q;

	assign valid       = lvl_q != 2'd0;
	assign rdata       = mem_q[rp_q];
	assign qstat.full  = lvl_q == 2'd2;
	assign qstat.level = lvl_q;

	// advance pointers and level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			lvl_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			lvl_q <= lvl_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

endmodule

@@ rtl/mag_back.sv @@
module mag_back #(
	parameter int MAX_COUNT = mag_pkg::MAX_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  mag_pkg::qent_t   q_data,
	output logic             pop,
	output logic             done,
	output mag_pkg::result_t result
);

	localparam int VB = mag_pkg::VALUE_BITS;
	localparam int CW = $clog2(MAX_COUNT + 1);
	localparam int AW = $clog2(MAX_COUNT);
	localparam int DW = (VB > CW) ? VB : CW;

	mag_pkg::bstate_t st_q, st_n;

	logic [VB-1:0] vmem [MAX_COUNT];
	mag_pkg::bkt_t bmem [MAX_COUNT];

	logic [CW-1:0] cnt_q, k_q, nb_q, sk_q;
	logic [VB-1:0] min_q, max_q, width_q, v_q, best_q, prev_q, vrd_q;
	logic          ovf_q, have_q, done_q, sv_s1;
	logic [AW-1:0] slot_q, sk_s1, init_q;
	mag_pkg::bkt_t brd_q;
	mag_pkg::result_t res_q;

	logic [VB-1:0] span, nv_min, nv_max, gap;
	logic          div_start, div_done;
	logic [DW-1:0] div_num, div_den, quo;
	logic [DW:0]   nb_w;
	logic [AW-1:0] vaddr, baddr, waddr, slot_c;
	logic          we;
	mag_pkg::bkt_t wdata;

	assign span = max_q - min_q;
	assign gap  = brd_q.low - prev_q;
	assign nb_w = {1'b0, quo} + 1'b1;
	assign slot_c = (quo >= DW'(nb_q)) ? AW'(nb_q - 1'b1) : quo[AW-1:0];

	mag_div #(.W(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	// next state
	always_comb begin
		st_n = st_q;
		unique case (st_q)
			mag_pkg::ST_INIT:  if (init_q == AW'(MAX_COUNT - 1)) st_n = mag_pkg::ST_IDLE;
			mag_pkg::ST_IDLE:  if (q_valid && q_data.last) st_n = mag_pkg::ST_PREP;
			mag_pkg::ST_PREP:  st_n = (cnt_q < CW'(2)) ? mag_pkg::ST_OUT : mag_pkg::ST_DIV_W;
			mag_pkg::ST_DIV_W: if (div_done) st_n = mag_pkg::ST_DIV_N;
			mag_pkg::ST_DIV_N: if (div_done) st_n = mag_pkg::ST_LOAD;
			mag_pkg::ST_LOAD:  st_n = mag_pkg::ST_DIV_S;
			mag_pkg::ST_DIV_S: if (div_done) st_n = mag_pkg::ST_BREAD;
			mag_pkg::ST_BREAD: st_n = (k_q + 1'b1 == cnt_q) ? mag_pkg::ST_SCAN : mag_pkg::ST_LOAD;
			mag_pkg::ST_SCAN:  if (sk_q == nb_q - 1'b1) st_n = mag_pkg::ST_TAIL;
			mag_pkg::ST_TAIL:  st_n = mag_pkg::ST_OUT;
			mag_pkg::ST_OUT:   st_n = mag_pkg::ST_IDLE;
			default:           st_n = mag_pkg::ST_INIT;
		endcase
	end

	// control outputs
	always_comb begin
		pop       = (st_q == mag_pkg::ST_IDLE) && q_valid;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		vaddr     = (st_q == mag_pkg::ST_BREAD) ? k_q[AW-1:0] + 1'b1 : k_q[AW-1:0];
		baddr     = (st_q == mag_pkg::ST_DIV_S) ? slot_c : sk_q[AW-1:0];
		we        = 1'b0;
		waddr     = init_q;
		wdata     = '0;
		unique case (st_q)
			mag_pkg::ST_PREP: begin
				div_start = cnt_q >= CW'(2);
				div_num   = DW'(span);
				div_den   = DW'(cnt_q);
			end
			mag_pkg::ST_DIV_W: begin
				div_start = div_done;
				div_num   = DW'(span);
				div_den   = DW'(quo[VB-1:0] + 1'b1);
			end
			mag_pkg::ST_LOAD: begin
				div_start = 1'b1;
				div_num   = DW'(vrd_q - min_q);
				div_den   = DW'(width_q);
			end
			default: ;
		endcase
		// bucket write port: clear sweep, update, or clear behind the scan
		priority if (st_q == mag_pkg::ST_INIT) begin
			we = 1'b1;
		end else if (st_q == mag_pkg::ST_BREAD) begin
			we         = 1'b1;
			waddr      = slot_q;
			wdata.used = 1'b1;
			wdata.low  = (brd_q.used && brd_q.low < v_q) ? brd_q.low : v_q;
			wdata.high = (brd_q.used && brd_q.high > v_q) ? brd_q.high : v_q;
		end else if (sv_s1) begin
			we    = 1'b1;
			waddr = sk_s1;
		end else begin
			we = 1'b0;
		end
	end

	// new extremes for a stored value
	always_comb begin
		nv_min = min_q;
		nv_max = max_q;
		if (cnt_q == '0) begin
			nv_min = q_data.value;
			nv_max = q_data.value;
		end else begin
			if (q_data.value < min_q) nv_min = q_data.value;
			if (q_data.value > max_q) nv_max = q_data.value;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (pop && q_data.store) vmem[cnt_q[AW-1:0]] <= q_data.value;
		vrd_q <= vmem[vaddr];
		if (we) bmem[waddr] <= wdata;
		brd_q <= bmem[baddr];
	end

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= mag_pkg::ST_INIT;
			init_q <= '0;
			cnt_q  <= '0;
			min_q  <= '0;
			max_q  <= '0;
			ovf_q  <= 1'b0;
			sv_s1  <= 1'b0;
			done_q <= 1'b0;
			have_q <= 1'b0;
			best_q <= '0;
		end else begin
			st_q   <= st_n;
			done_q <= st_q == mag_pkg::ST_OUT;
			sv_s1  <= st_q == mag_pkg::ST_SCAN;
			if (st_q == mag_pkg::ST_INIT) init_q <= init_q + 1'b1;
			if (pop) begin
				if (q_data.store) begin
					cnt_q <= cnt_q + 1'b1;
					min_q <= nv_min;
					max_q <= nv_max;
				end
				if (q_data.last) ovf_q <= q_data.ovf;
			end
			if (st_q == mag_pkg::ST_PREP) begin
				best_q <= '0;
				have_q <= 1'b0;
			end
			// fold one scanned bucket
			if (sv_s1 && brd_q.used) begin
				if (have_q && gap > best_q) best_q <= gap;
				have_q <= 1'b1;
			end
			if (st_q == mag_pkg::ST_OUT) begin
				cnt_q <= '0;
				min_q <= '0;
				max_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sv_s1 && brd_q.used) prev_q <= brd_q.high;
		if (st_q == mag_pkg::ST_PREP) k_q <= '0;
		if (st_q == mag_pkg::ST_BREAD) k_q <= k_q + 1'b1;
		if (st_q == mag_pkg::ST_DIV_W && div_done) width_q <= quo[VB-1:0] + 1'b1;
		if (st_q == mag_pkg::ST_DIV_N && div_done) begin
			nb_q <= (nb_w > (DW+1)'(MAX_COUNT)) ? CW'(MAX_COUNT) : CW'(nb_w);
			sk_q <= '0;
		end
		if (st_q == mag_pkg::ST_LOAD) v_q <= vrd_q;
		if (st_q == mag_pkg::ST_DIV_S && div_done) slot_q <= slot_c;
		if (st_q == mag_pkg::ST_SCAN) begin
			sk_q  <= sk_q + 1'b1;
			sk_s1 <= sk_q[AW-1:0];
		end
		if (st_q == mag_pkg::ST_OUT) begin
			res_q.max_gap    <= best_q;
			res_q.overflowed <= ovf_q;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

@@ rtl/maximum_adjacent_gap_bucketed.sv @@
// Channel  | Handshake          | Word
// ---------+--------------------+------------------------------------
// input    | start, busy        | item   (sample_value, end_of_set)
// result   | done (one cycle)   | result (max_gap, overflowed)
//
// A value is queued; the back end then stores it while the set has room. On the last
// value each stored value costs one pass of the shared restoring divider, then the
// buckets are scanned in turn. After reset the back end clears the bucket memory
// before it goes idle. busy rises while the two-entry queue is full; results cannot
// be stalled.
module maximum_adjacent_gap_bucketed #(
	parameter int MAX_COUNT = mag_pkg::MAX_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  mag_pkg::item_t   item,
	output logic             busy,
	output logic             done,
	output mag_pkg::result_t result
);

	logic            push, pop, q_valid;
	mag_pkg::qent_t  pdata, q_data;
	mag_pkg::qstat_t qstat;

	mag_front #(.MAX_COUNT(MAX_COUNT)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.qstat  (qstat),
		.busy   (busy),
		.push   (push),
		.pdata  (pdata)
	);

	mag_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (pdata),
		.pop    (pop),
		.valid  (q_valid),
		.rdata  (q_data),
		.qstat  (qstat)
	);

	mag_back #(.MAX_COUNT(MAX_COUNT)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.pop     (pop),
		.done    (done),
		.result  (result)
	);

`ifndef ASSERT_OFF
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.level != 2'd3) else $error("queue level out of range");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> qstat.level == 2'd2) else $error("busy without full queue");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("results back to back");
`endif

endmodule

@@ tb/testbench.sv @@
module testbench;

	localparam int CAP = 1024;
	localparam int VB = mag_pkg::VALUE_BITS;
	localparam logic [VB-1:0] VMAX = {VB{1'b1}};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	mag_pkg::item_t   item = '0;
	logic             busy;
	logic             done;
	mag_pkg::result_t result;

	maximum_adjacent_gap_bucketed #(.MAX_COUNT(CAP)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item),
		.busy(busy), .done(done), .result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	mag_pkg::item_t   pending_words[$];
	mag_pkg::result_t gap_expect[$];
	int               idle_pct = 0;
	bit               hold_off = 1'b0;
	int               err_count = 0;
	bit               all_queued = 1'b0;

	// running set state of the predictor
	logic [VB-1:0] set_vals[CAP];
	int            set_count = 0;
	logic [VB-1:0] set_min, set_max;
	bit            set_ovf = 1'b0;

	// bucket pigeonhole gap over the current set
	function automatic logic [VB-1:0] bucket_gap();
		logic [VB-1:0] lo[CAP], hi[CAP], best, prev_hi, span, width, v;
		bit            used[CAP], have_prev;
		longint        nb, slot;
		best = '0;
		prev_hi = '0;
		have_prev = 1'b0;
		if (set_count < 2) return '0;
		span = set_max - set_min;
		width = VB'(span / set_count + 1);
		nb = span / width + 1;
		if (nb > CAP) nb = CAP;
		for (int k = 0; k < CAP; k++) used[k] = 1'b0;
		for (int k = 0; k < set_count; k++) begin
			v = set_vals[k];
			slot = (v - set_min) / width;
			if (slot >= nb) slot = nb - 1;
			if (!used[slot]) begin
				used[slot] = 1'b1;
				lo[slot] = v;
				hi[slot] = v;
			end else begin
				if (v < lo[slot]) lo[slot] = v;
				if (v > hi[slot]) hi[slot] = v;
			end
		end
		for (int k = 0; k < nb; k++) begin
			if (used[k]) begin
				if (have_prev && lo[k] - prev_hi > best) best = lo[k] - prev_hi;
				prev_hi = hi[k];
				have_prev = 1'b1;
			end
		end
		return best;
	endfunction

	// advance the predictor by one accepted word
	task automatic predict_word(input mag_pkg::item_t w);
		mag_pkg::result_t r;
		if (set_count < CAP) begin
			if (set_count == 0) begin
				set_min = w.sample_value;
				set_max = w.sample_value;
			end else begin
				if (w.sample_value < set_min) set_min = w.sample_value;
				if (w.sample_value > set_max) set_max = w.sample_value;
			end
			set_vals[set_count] = w.sample_value;
			set_count++;
		end else begin
			set_ovf = 1'b1;
		end
		if (w.end_of_set) begin
			r.max_gap = bucket_gap();
			r.overflowed = set_ovf;
			gap_expect.insert(gap_expect.size(), r);
			set_count = 0;
			set_ovf = 1'b0;
		end
	endtask

	bit accepted;
	always @(posedge clk) begin
		accepted <= arst_n && start && !busy;
		if (arst_n && start && !busy) begin
			predict_word(item);
		end
	end

	// drive words at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !accepted) begin
				// hold the word until taken
			end else if (pending_words.size() > 0 && !hold_off &&
					$urandom_range(99) >= idle_pct) begin
				item <= pending_words.pop_front();
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// check results
	always @(posedge clk) begin
		mag_pkg::result_t exp_r;
		if (arst_n && done) begin
			if (gap_expect.size() == 0) begin
				$display("%0t unexpected result gap=%0d ovf=%0b", $time,
					result.max_gap, result.overflowed);
				err_count++;
			end else begin
				exp_r = gap_expect.pop_front();
				if (result.max_gap !== exp_r.max_gap) begin
					$display("%0t max_gap expected %0d actual %0d", $time,
						exp_r.max_gap, result.max_gap);
					err_count++;
				end
				if (result.overflowed !== exp_r.overflowed) begin
					$display("%0t overflowed expected %0b actual %0b", $time,
						exp_r.overflowed, result.overflowed);
					err_count++;
				end
			end
		end
	end

	task automatic add_word(input logic [VB-1:0] v, input bit last);
		mag_pkg::item_t w;
		w.sample_value = v;
		w.end_of_set = last;
		pending_words.insert(pending_words.size(), w);
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || start || gap_expect.size() > 0)
			@(posedge clk);
	endtask

	// random set: values over full, narrow, both-end or masked range
	task automatic rand_set(input int n);
		logic [VB-1:0] base, v;
		int            mode;
		mode = $urandom_range(3);
		base = VB'($urandom);
		for (int k = 0; k < n; k++) begin
			case (mode)
				0: v = VB'($urandom);
				1: v = VB'(base + $urandom_range(40));
				2: v = $urandom_range(1) ? VB'(VMAX - $urandom_range(9)) :
					VB'($urandom_range(9));
				default: v = VB'($urandom & ({VB{1'b1}} >> $urandom_range(30)));
			endcase
			add_word(v, k == n - 1);
		end
	endtask

	initial begin
		int total;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed sets
		add_word('0, 1'b1);
		add_word(VMAX, 1'b0); add_word('0, 1'b1);
		add_word(VB'(5), 1'b0); add_word(VB'(5), 1'b0); add_word(VB'(5), 1'b1);
		add_word(VB'(1), 1'b0); add_word(VB'(9), 1'b0); add_word(VB'(3), 1'b0);
		add_word(VB'(4), 1'b1);
		add_word(VMAX, 1'b0); add_word(VB'(VMAX - 1), 1'b0); add_word(VB'(100), 1'b1);
		add_word(31'h2AAAAAAA, 1'b0); add_word(31'h55555555, 1'b1);
		drain();

		// random phases with differing idle rates
		total = 0;
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 0) ? 0 : (ph == 3 ? 20 : 76);
			while (total < 140 * (ph + 1)) begin
				int n;
				n = $urandom_range(9) == 0 ? $urandom_range(60, 20) : $urandom_range(6, 1);
				rand_set(n);
				total += n;
			end
			drain();
			// pause the sender after all results are in
			hold_off = 1'b1;
			repeat (5) @(posedge clk);
			hold_off = 1'b0;
		end
		repeat (200) @(posedge clk);
		if (err_count == 0 && gap_expect.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#20000000;
		$display("testbench: errors");
		$finish;
	end
endmodule
